[src/rgb_led_serial_bit_encoder_assert.svh]
// Assertion macros for the serial bit encoder, sampled on clk and quiet during reset.
`ifndef RGB_LED_SERIAL_BIT_ENCODER_ASSERT_SVH
`define RGB_LED_SERIAL_BIT_ENCODER_ASSERT_SVH

// Same-cycle implication: when ante holds, cons must hold on that edge.
`define RLSE_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication: when ante holds, cons must hold on the following edge.
`define RLSE_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[src/rlse_pkg.sv]
// Shared types and constants for the RGB LED serial bit encoder.
package rlse_pkg;

  localparam int MAX_LEDS_DEF = 256;

  localparam logic [4:0] TOP_BIT = 5'd23;

  localparam logic [7:0] ONE_HIGH_RST  = 8'd60;
  localparam logic [7:0] ZERO_HIGH_RST = 8'd30;
  localparam logic [8:0] LED_COUNT_RST = 9'd256;

  localparam int CFG_DATA_W = 9;
  localparam int CFG_IDX_W  = 2;

  typedef enum logic [1:0] {
    CMD_TICK  = 2'd0,
    CMD_WRITE = 2'd1,
    CMD_START = 2'd2
  } cmd_t;

  typedef enum logic [1:0] {
    REG_ONE_HIGH  = 2'd0,
    REG_ZERO_HIGH = 2'd1,
    REG_LED_COUNT = 2'd2
  } reg_idx_t;

  typedef enum logic {
    PH_CLEAR,
    PH_READY
  } phase_t;

endpackage

[src/rlse_if.sv]
// Handshake interfaces for the command input channel and the bit result channel.
interface rlse_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] cmd;
  logic [8:0] pixel_index;
  logic [7:0] red;
  logic [7:0] green;
  logic [7:0] blue;

  modport source (output valid, output cmd, output pixel_index, output red,
                  output green, output blue, input ready);
  modport sink   (input valid, input cmd, input pixel_index, input red,
                  input green, input blue, output ready);
endinterface

interface rlse_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] duty_count;
  logic       bit_sent;
  logic       frame_last_bit;

  modport source (output valid, output duty_count, output bit_sent,
                  output frame_last_bit, input ready);
  modport sink   (input valid, input duty_count, input bit_sent,
                  input frame_last_bit, output ready);
endinterface

[src/rgb_led_serial_bit_encoder.sv]
// Top level of the RGB LED serial bit encoder: pixel store, bit sequencer and result register.
//
//   channel  direction  carries
//   in_ch    sink       cmd, pixel_index, red, green, blue
//   out_ch   source     duty_count, bit_sent, frame_last_bit (one item per tick)
//   cfg_*    sink       one_high_count, zero_high_count, led_count writes
//
// Throughput is one item per cycle while the output is not stalled; a tick's
// result passes through the synchronous read of the pixel store and then the
// output register.
// After reset the pixel store is swept to zero, one entry a cycle, so the input
// is held off until the sweep ends; configuration writes are taken throughout.
// A stalled output holds the result register and the read stage behind it, and
// the input is held off only when both are full.
`include "rgb_led_serial_bit_encoder_assert.svh"

module rgb_led_serial_bit_encoder #(
  parameter int MAX_LEDS = rlse_pkg::MAX_LEDS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  rlse_in_if.sink                         in_ch,
  rlse_out_if.source                      out_ch,
  input  logic                            cfg_we,
  input  logic [rlse_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [rlse_pkg::CFG_DATA_W-1:0] cfg_data
);

  // Pointer width covers the store depth; count width holds MAX_LEDS and the
  // nine-bit led_count register alike.
  localparam int PW = (MAX_LEDS > 1) ? $clog2(MAX_LEDS) : 1;
  localparam int CW = (PW + 1 > 10) ? PW + 1 : 10;
  localparam logic [CW-1:0] MAX_C   = CW'(MAX_LEDS);
  localparam logic [PW-1:0] LAST_PA = PW'(MAX_LEDS - 1);

  // Configuration registers.
  logic [7:0] one_high_r;
  logic [7:0] zero_high_r;
  logic [8:0] led_count_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      one_high_r  <= rlse_pkg::ONE_HIGH_RST;
      zero_high_r <= rlse_pkg::ZERO_HIGH_RST;
      led_count_r <= rlse_pkg::LED_COUNT_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        rlse_pkg::REG_ONE_HIGH:  one_high_r  <= cfg_data[7:0];
        rlse_pkg::REG_ZERO_HIGH: zero_high_r <= cfg_data[7:0];
        rlse_pkg::REG_LED_COUNT: led_count_r <= cfg_data[8:0];
        default: ;
      endcase
    end
  end

  // Clearing sweep after reset.
  rlse_pkg::phase_t phase_r, phase_nxt;
  logic [PW-1:0]    clr_addr_r, clr_addr_nxt;

  always_comb begin
    phase_nxt = phase_r;
    unique case (phase_r)
      rlse_pkg::PH_CLEAR: if (clr_addr_r == LAST_PA) phase_nxt = rlse_pkg::PH_READY;
      rlse_pkg::PH_READY: phase_nxt = rlse_pkg::PH_READY;
      default:            phase_nxt = rlse_pkg::PH_CLEAR;
    endcase
  end

  always_comb begin
    clr_addr_nxt = clr_addr_r;
    if (phase_r == rlse_pkg::PH_CLEAR) begin
      clr_addr_nxt = clr_addr_r + PW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r    <= rlse_pkg::PH_CLEAR;
      clr_addr_r <= '0;
    end else begin
      phase_r    <= phase_nxt;
      clr_addr_r <= clr_addr_nxt;
    end
  end

  // Handshake of the pipeline: read stage feeds the output register.
  logic s1_valid_r;
  logic out_valid_r;
  logic s1_adv;
  logic in_acc;

  assign s1_adv      = s1_valid_r && (!out_valid_r || out_ch.ready);
  assign in_ch.ready = (phase_r == rlse_pkg::PH_READY) && (!s1_valid_r || s1_adv);
  assign in_acc      = in_ch.valid && in_ch.ready;

  logic is_tick, is_write, is_start;
  assign is_tick  = in_acc && (in_ch.cmd == rlse_pkg::CMD_TICK);
  assign is_write = in_acc && (in_ch.cmd == rlse_pkg::CMD_WRITE);
  assign is_start = in_acc && (in_ch.cmd == rlse_pkg::CMD_START);

  // Frame sequencer.
  logic          running_r;
  logic [4:0]    bit_pos_r;
  logic [PW-1:0] ptr_r;
  logic [CW-1:0] eff_count;
  logic          last_pixel;
  logic          frame_end;

  // led_count of zero counts as one pixel, and is capped at the store depth.
  always_comb begin
    priority if (led_count_r == 9'd0) begin
      eff_count = CW'(1);
    end else if (CW'(led_count_r) > MAX_C) begin
      eff_count = MAX_C;
    end else begin
      eff_count = CW'(led_count_r);
    end
  end

  assign last_pixel = (CW'(ptr_r) + CW'(1)) >= eff_count;
  assign frame_end  = running_r && (bit_pos_r == 5'd0) && last_pixel;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      running_r <= 1'b0;
      bit_pos_r <= rlse_pkg::TOP_BIT;
      ptr_r     <= '0;
    end else if (is_start && !running_r) begin
      running_r <= 1'b1;
      bit_pos_r <= rlse_pkg::TOP_BIT;
      ptr_r     <= '0;
    end else if (is_tick && running_r) begin
      if (bit_pos_r == 5'd0) begin
        bit_pos_r <= rlse_pkg::TOP_BIT;
        if (last_pixel) begin
          ptr_r     <= '0;
          running_r <= 1'b0;
        end else begin
          ptr_r <= ptr_r + PW'(1);
        end
      end else begin
        bit_pos_r <= bit_pos_r - 5'd1;
      end
    end
  end

  // Pixel store. Writes and reads come from items in order, one per cycle, so
  // a write is always in the array before any later tick reads that entry.
  logic [23:0]   pixel_store [MAX_LEDS];
  logic [23:0]   rd_word_r;
  logic          mem_we;
  logic [PW-1:0] mem_wa;
  logic [23:0]   mem_wd;
  logic          wr_hit;
  logic [CW-1:0] wr_idx;

  assign wr_idx = CW'(in_ch.pixel_index);
  assign wr_hit = is_write && (in_ch.pixel_index != 9'd0) && (wr_idx <= MAX_C);

  always_comb begin
    if (phase_r == rlse_pkg::PH_CLEAR) begin
      mem_we = 1'b1;
      mem_wa = clr_addr_r;
      mem_wd = '0;
    end else begin
      mem_we = wr_hit;
      mem_wa = PW'(wr_idx - CW'(1));
      mem_wd = {in_ch.green, in_ch.red, in_ch.blue};
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      pixel_store[mem_wa] <= mem_wd;
    end
    if (is_tick && running_r) begin
      rd_word_r <= pixel_store[ptr_r];
    end
  end

  // Read stage side information.
  logic       s1_run_r;
  logic [4:0] s1_bit_pos_r;
  logic       s1_last_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (is_tick) begin
      s1_valid_r <= 1'b1;
    end else if (s1_adv) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (is_tick) begin
      s1_run_r     <= running_r;
      s1_bit_pos_r <= bit_pos_r;
      s1_last_r    <= frame_end;
    end
  end

  // Bit selection and the output register. An idle tick gives all zeros.
  logic       data_bit;
  logic [7:0] duty_nxt;
  logic [23:0] shifted;

  assign shifted  = rd_word_r >> s1_bit_pos_r;
  assign data_bit = shifted[0];
  assign duty_nxt = !s1_run_r ? 8'd0 : (data_bit ? one_high_r : zero_high_r);

  logic [7:0] out_duty_r;
  logic       out_sent_r;
  logic       out_last_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_adv) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      out_duty_r <= duty_nxt;
      out_sent_r <= s1_run_r;
      out_last_r <= s1_last_r;
    end
  end

  assign out_ch.valid          = out_valid_r;
  assign out_ch.duty_count     = out_duty_r;
  assign out_ch.bit_sent       = out_sent_r;
  assign out_ch.frame_last_bit = out_last_r;

  // Checks on the sequencer and the pipeline.
  `RLSE_ASSERT_IMP(a_clear_holds_input, phase_r == rlse_pkg::PH_CLEAR, !in_ch.ready,
                   "input accepted during the clearing sweep")
  `RLSE_ASSERT_IMP(a_last_needs_sent, out_valid_r && out_last_r, out_sent_r,
                   "frame end flagged on an idle tick")
  `RLSE_ASSERT_IMP(a_idle_zero_duty, out_valid_r && !out_sent_r, out_duty_r == 8'd0,
                   "idle tick gave a non-zero duty count")
  `RLSE_ASSERT_NXT(a_frame_end_idle, is_tick && frame_end, !running_r,
                   "sequencer still running after the final bit")
  `RLSE_ASSERT_IMP(a_bit_pos_range, 1'b1, bit_pos_r <= rlse_pkg::TOP_BIT,
                   "bit position beyond the top bit")

endmodule
